// ----- sv/http_request_byte_parser_defines.svh -----
// Assertion macros for the HTTP request byte parser.
`ifndef HTTP_REQUEST_BYTE_PARSER_DEFINES_SVH
`define HTTP_REQUEST_BYTE_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define HRP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HRP_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HRP_ASSERT(label, clk, rst_n, prop, msg)
`define HRP_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ----- sv/hrp_pkg.sv -----
// Package for the HTTP request byte parser: types, codes and character helpers.
`default_nettype none
package hrp_pkg;

    localparam int COUNT_BITS_DEF = 64;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [4:0] {
        S_METHOD_START = 5'd0,  S_METHOD = 5'd1,     S_URI = 5'd2,
        S_VH = 5'd3,            S_VT1 = 5'd4,        S_VT2 = 5'd5,
        S_VP = 5'd6,            S_VSLASH = 5'd7,     S_MAJ_START = 5'd8,
        S_MAJ = 5'd9,           S_MIN_START = 5'd10, S_MIN = 5'd11,
        S_NL1 = 5'd12,          S_LINE_START = 5'd13, S_LWS = 5'd14,
        S_NAME = 5'd15,         S_SPACE = 5'd16,     S_VALUE = 5'd17,
        S_NL2 = 5'd18,          S_NL3 = 5'd19,       S_CLEN_START = 5'd20,
        S_CLEN = 5'd21,         S_CLEN_NL = 5'd22,   S_CHUNK = 5'd23,
        S_CHUNK_NL = 5'd24,     S_TERM_CR = 5'd25,   S_TERM_LF = 5'd26,
        S_TRAIL_START = 5'd27,  S_TERM_NL = 5'd28,   S_FIXED = 5'd29,
        S_DONE = 5'd30,         S_VALUE_CONT = 5'd31
    } state_t;

    localparam logic [1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [1:0] ST_COMPLETE   = 2'd1;
    localparam logic [1:0] ST_INVALID    = 2'd2;

    localparam logic [2:0] CLS_NONE   = 3'd0;
    localparam logic [2:0] CLS_METHOD = 3'd1;
    localparam logic [2:0] CLS_URI    = 3'd2;
    localparam logic [2:0] CLS_NAME   = 3'd3;
    localparam logic [2:0] CLS_VALUE  = 3'd4;
    localparam logic [2:0] CLS_BODY   = 3'd5;

    localparam logic [4:0] V_NONE          = 5'd0;
    localparam logic [4:0] V_TE0           = 5'd1;
    localparam logic [4:0] V_CHUNKED_FULL  = 5'd8;
    localparam logic [4:0] V_IDENTITY_FULL = 5'd16;
    localparam logic [4:0] V_TE_MISS       = 5'd17;
    localparam logic [4:0] V_CL_EMPTY      = 5'd18;
    localparam logic [4:0] V_CL_DIGITS     = 5'd19;

    localparam logic [1:0] ENC_NONE     = 2'd0;
    localparam logic [1:0] ENC_CHUNKED  = 2'd1;
    localparam logic [1:0] ENC_IDENTITY = 2'd2;
    localparam logic [1:0] ENC_OTHER    = 2'd3;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Input item as carried on the input channel.
    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } in_item_t;

    // Classified byte handed from the front part to the back part.
    typedef struct packed {
        logic       restart;
        logic [7:0] data_byte;
        logic       tok;
        logic       ctl;
        logic       digit;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic [7:0] low;
    } cls_item_t;

    // Result item as carried on the output channel.
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] byte_class;
        logic [7:0] out_byte;
        logic       header_done;
        logic [7:0] major_version;
        logic [7:0] minor_version;
    } out_item_t;

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        to_lower = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    endfunction

    function automatic logic is_ctl(input logic [7:0] b);
        is_ctl = (b <= 8'd31) || (b == 8'd127);
    endfunction

    function automatic logic is_token(input logic [7:0] b);
        case (b)
            "(", ")", "<", "@", ",", ";", ":", "\\", "\"", "/", "[", "]",
            "?", "=", "{", "}", " ", 8'h09: is_token = 1'b0;
            default: is_token = (b <= 8'd127) && !is_ctl(b);
        endcase
    endfunction

    // Lower-case name text by position.
    function automatic logic [7:0] te_char(input logic [4:0] p);
        case (p)
            5'd0: te_char = "t";  5'd1: te_char = "r";  5'd2: te_char = "a";
            5'd3: te_char = "n";  5'd4: te_char = "s";  5'd5: te_char = "f";
            5'd6: te_char = "e";  5'd7: te_char = "r";  5'd8: te_char = "-";
            5'd9: te_char = "e";  5'd10: te_char = "n"; 5'd11: te_char = "c";
            5'd12: te_char = "o"; 5'd13: te_char = "d"; 5'd14: te_char = "i";
            5'd15: te_char = "n"; 5'd16: te_char = "g";
            default: te_char = 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] cl_char(input logic [4:0] p);
        case (p)
            5'd0: cl_char = "c";  5'd1: cl_char = "o";  5'd2: cl_char = "n";
            5'd3: cl_char = "t";  5'd4: cl_char = "e";  5'd5: cl_char = "n";
            5'd6: cl_char = "t";  5'd7: cl_char = "-";  5'd8: cl_char = "l";
            5'd9: cl_char = "e";  5'd10: cl_char = "n"; 5'd11: cl_char = "g";
            5'd12: cl_char = "t"; 5'd13: cl_char = "h";
            default: cl_char = 8'd0;
        endcase
    endfunction

    // Expected value characters for the encoding match codes.
    function automatic logic [7:0] enc_char(input logic [4:0] code);
        case (code)
            5'd2: enc_char = "h";  5'd3: enc_char = "u";  5'd4: enc_char = "n";
            5'd5: enc_char = "k";  5'd6: enc_char = "e";  5'd7: enc_char = "d";
            5'd9: enc_char = "d";  5'd10: enc_char = "e"; 5'd11: enc_char = "n";
            5'd12: enc_char = "t"; 5'd13: enc_char = "i"; 5'd14: enc_char = "t";
            5'd15: enc_char = "y";
            default: enc_char = 8'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ----- sv/hrp_stream_if.sv -----
// Valid/ready stream interface carrying one payload type.
`default_nettype none
interface hrp_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- sv/hrp_front.sv -----
// Front part: accepts input bytes and classifies each into character flags.
`default_nettype none
module hrp_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire hrp_pkg::in_item_t    in_item,
    output logic                      q_valid,
    input  wire logic                 q_ready,
    output hrp_pkg::cls_item_t        q_item
);
    import hrp_pkg::*;

    logic      full_reg;
    cls_item_t item_reg;
    cls_item_t item_next;
    logic [7:0] b;

    // Character classification of the incoming byte.
    always_comb
    begin
        b = in_item.data_byte;
        item_next.restart   = (in_item.op == OP_RESTART);
        item_next.data_byte = b;
        item_next.tok       = is_token(b);
        item_next.ctl       = is_ctl(b);
        item_next.digit     = (b >= "0" && b <= "9");
        item_next.low       = to_lower(b);
        item_next.hex_ok    = 1'b1;
        item_next.hex_val   = 4'd0;
        if (b >= "0" && b <= "9")
        begin
            item_next.hex_val = 4'(b - "0");
        end
        else if (b >= "a" && b <= "f")
        begin
            item_next.hex_val = 4'(b - "a" + 8'd10);
        end
        else if (b >= "A" && b <= "F")
        begin
            item_next.hex_val = 4'(b - "A" + 8'd10);
        end
        else
        begin
            item_next.hex_ok = 1'b0;
        end
    end

    assign in_ready = !full_reg || q_ready;
    assign q_valid  = full_reg;
    assign q_item   = item_reg;

    // One-entry pipeline register toward the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end
endmodule
`default_nettype wire

// ----- sv/hrp_queue.sv -----
// Short queue between the classifying front part and the parsing back part.
`default_nettype none
module hrp_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_valid,
    output logic                      wr_ready,
    input  wire hrp_pkg::cls_item_t   wr_item,
    output logic                      rd_valid,
    input  wire logic                 rd_ready,
    output hrp_pkg::cls_item_t        rd_item
);
    import hrp_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    cls_item_t         mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]     wp_reg;
    logic [AW-1:0]     rp_reg;
    logic [AW:0]       cnt_reg;
    logic              wr_fire;
    logic              rd_fire;

    assign wr_ready = (cnt_reg != (AW+1)'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = mem_reg[rp_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_fire)
            begin
                wp_reg <= (wp_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd_fire)
            begin
                rp_reg <= (rp_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr_fire) - (AW+1)'(rd_fire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            mem_reg[wp_reg] <= wr_item;
        end
    end
endmodule
`default_nettype wire

// ----- sv/hrp_back.sv -----
// Back part: the request parse state machine and registered result output.
`default_nettype none
module hrp_back #(
    parameter int COUNT_BITS = hrp_pkg::COUNT_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    output logic                      q_ready,
    input  wire hrp_pkg::cls_item_t   q_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output hrp_pkg::out_item_t        out_item
);
    import hrp_pkg::*;

    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    state_t                state_reg, state_next;
    logic [7:0]            major_reg, major_next, minor_reg, minor_next;
    logic [COUNT_BITS-1:0] left_reg, left_next, len_reg, len_next;
    logic                  seen_reg, seen_next, lfound_reg, lfound_next;
    logic [4:0]            pos_reg, pos_next, code_reg, code_next;
    logic [1:0]            flags_reg, flags_next, enc_reg, enc_next;
    logic                  ovalid_reg;
    out_item_t             oitem_reg, oitem_next;

    logic       fire;
    logic [1:0] st;
    logic [2:0] cls;
    logic       hd;
    logic [7:0] b;
    logic [4:0] code;
    logic [COUNT_BITS+3:0] dec_acc, hex_acc;
    logic [11:0] ver_acc;

    assign q_ready   = !ovalid_reg || out_ready;
    assign fire      = q_valid && q_ready;
    assign out_valid = ovalid_reg;
    assign out_item  = oitem_reg;

    // Next state and result of one byte.
    always_comb
    begin
        b = q_item.data_byte;
        code = code_reg;
        state_next = state_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        left_next  = left_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        lfound_next = lfound_reg;
        pos_next   = pos_reg;
        code_next  = code_reg;
        flags_next = flags_reg;
        enc_next   = enc_reg;
        st = ST_INCOMPLETE;
        cls = CLS_NONE;
        hd = 1'b0;
        dec_acc = ({4'd0, len_reg} << 3) + ({4'd0, len_reg} << 1)
                  + (COUNT_BITS+4)'(q_item.hex_val);
        hex_acc = ({4'd0, left_reg} << 4) + (COUNT_BITS+4)'(q_item.hex_val);
        ver_acc = 12'd0;
        if (q_item.restart)
        begin
            state_next = S_METHOD_START;
            major_next = '0;
            minor_next = '0;
            left_next = '0;
            len_next = '0;
            seen_next = 1'b0;
            pos_next = '0;
            flags_next = 2'b11;
            code_next = V_NONE;
            enc_next = ENC_NONE;
            lfound_next = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_METHOD_START:
                    if (q_item.tok) begin state_next = S_METHOD; cls = CLS_METHOD; end
                    else st = ST_INVALID;
                S_METHOD:
                    if (b == " ") state_next = S_URI;
                    else if (q_item.tok) cls = CLS_METHOD;
                    else st = ST_INVALID;
                S_URI:
                    if (b == " ") state_next = S_VH;
                    else if (q_item.ctl) st = ST_INVALID;
                    else cls = CLS_URI;
                S_VH:  if (b == "H") state_next = S_VT1; else st = ST_INVALID;
                S_VT1: if (b == "T") state_next = S_VT2; else st = ST_INVALID;
                S_VT2: if (b == "T") state_next = S_VP; else st = ST_INVALID;
                S_VP:  if (b == "P") state_next = S_VSLASH; else st = ST_INVALID;
                S_VSLASH:
                    if (b == "/")
                    begin
                        state_next = S_MAJ_START;
                        major_next = '0;
                        minor_next = '0;
                    end
                    else st = ST_INVALID;
                S_MAJ_START:
                    if (q_item.digit)
                    begin
                        state_next = S_MAJ;
                        major_next = {4'd0, q_item.hex_val};
                    end
                    else st = ST_INVALID;
                S_MAJ:
                    if (b == ".") state_next = S_MIN_START;
                    else if (q_item.digit)
                    begin
                        ver_acc = {4'd0, major_reg} * 12'd10 + 12'(q_item.hex_val);
                        major_next = (ver_acc > 12'd255) ? 8'd255 : ver_acc[7:0];
                    end
                    else st = ST_INVALID;
                S_MIN_START:
                    if (q_item.digit)
                    begin
                        state_next = S_MIN;
                        minor_next = {4'd0, q_item.hex_val};
                    end
                    else st = ST_INVALID;
                S_MIN:
                    if (b == 8'h0D) state_next = S_NL1;
                    else if (q_item.digit)
                    begin
                        ver_acc = {4'd0, minor_reg} * 12'd10 + 12'(q_item.hex_val);
                        minor_next = (ver_acc > 12'd255) ? 8'd255 : ver_acc[7:0];
                    end
                    else st = ST_INVALID;
                S_NL1: if (b == 8'h0A) state_next = S_LINE_START; else st = ST_INVALID;
                S_LINE_START:
                    if (b == 8'h0D) state_next = S_NL3;
                    else if (seen_reg && (b == " " || b == 8'h09)) state_next = S_LWS;
                    else if (q_item.tok)
                    begin
                        state_next = S_NAME;
                        cls = CLS_NAME;
                        code_next = V_NONE;
                        flags_next = 2'b11;
                        if (q_item.low != te_char(5'd0)) flags_next[0] = 1'b0;
                        if (q_item.low != cl_char(5'd0)) flags_next[1] = 1'b0;
                        pos_next = 5'd1;
                    end
                    else st = ST_INVALID;
                S_LWS:
                    if (b == 8'h0D) state_next = S_NL2;
                    else if (b == " " || b == 8'h09)
                    begin
                        state_next = S_LWS;
                    end
                    else if (q_item.ctl || code == V_CL_EMPTY || code == V_CL_DIGITS)
                        st = ST_INVALID;
                    else
                    begin
                        if (code >= V_TE0 && code <= V_TE_MISS)
                        begin
                            code_next = V_TE_MISS;
                            enc_next = ENC_OTHER;
                        end
                        state_next = S_VALUE_CONT;
                        cls = CLS_VALUE;
                    end
                S_NAME:
                    if (b == ":")
                    begin
                        state_next = S_SPACE;
                        code_next = V_NONE;
                        if (flags_reg[0] && pos_reg == 5'd17 && enc_reg == ENC_NONE)
                        begin
                            enc_next = ENC_OTHER;
                            code_next = V_TE0;
                        end
                        else if (flags_reg[1] && pos_reg == 5'd14 && !lfound_reg)
                        begin
                            lfound_next = 1'b1;
                            len_next = '0;
                            code_next = V_CL_EMPTY;
                        end
                    end
                    else if (q_item.tok)
                    begin
                        cls = CLS_NAME;
                        if (pos_reg >= 5'd17 || q_item.low != te_char(pos_reg))
                            flags_next[0] = 1'b0;
                        if (pos_reg >= 5'd14 || q_item.low != cl_char(pos_reg))
                            flags_next[1] = 1'b0;
                        if (pos_reg != 5'd31) pos_next = pos_reg + 5'd1;
                    end
                    else st = ST_INVALID;
                S_SPACE: if (b == " ") state_next = S_VALUE; else st = ST_INVALID;
                S_VALUE:
                    if (b == 8'h0D)
                    begin
                        if (code == V_CL_EMPTY) st = ST_INVALID;
                        else
                        begin
                            if (code >= V_TE0 && code <= V_TE_MISS)
                                enc_next = (code == V_CHUNKED_FULL) ? ENC_CHUNKED :
                                           (code == V_IDENTITY_FULL) ? ENC_IDENTITY : ENC_OTHER;
                            state_next = S_NL2;
                            hd = 1'b1;
                            seen_next = 1'b1;
                        end
                    end
                    else if (q_item.ctl) st = ST_INVALID;
                    else if (code == V_CL_EMPTY || code == V_CL_DIGITS)
                    begin
                        if (!q_item.digit) st = ST_INVALID;
                        else
                        begin
                            len_next = (dec_acc[COUNT_BITS+3:COUNT_BITS] != 4'd0)
                                       ? CMAX : dec_acc[COUNT_BITS-1:0];
                            code_next = V_CL_DIGITS;
                            cls = CLS_VALUE;
                        end
                    end
                    else
                    begin
                        if (code == V_TE0)
                            code_next = (q_item.low == "c") ? 5'd2 :
                                        (q_item.low == "i") ? 5'd9 : V_TE_MISS;
                        else if ((code >= 5'd2 && code <= 5'd7) ||
                                 (code >= 5'd9 && code <= 5'd15))
                            code_next = (q_item.low == enc_char(code)) ? code + 5'd1 : V_TE_MISS;
                        else if (code >= V_TE0 && code <= V_TE_MISS)
                            code_next = V_TE_MISS;
                        cls = CLS_VALUE;
                    end
                S_VALUE_CONT:
                    if (b == 8'h0D) state_next = S_NL2;
                    else if (q_item.ctl) st = ST_INVALID;
                    else cls = CLS_VALUE;
                S_NL2: if (b == 8'h0A) state_next = S_LINE_START; else st = ST_INVALID;
                S_NL3:
                    if (b != 8'h0A || enc_reg == ENC_OTHER) st = ST_INVALID;
                    else if (enc_reg == ENC_CHUNKED) state_next = S_CLEN_START;
                    else if (lfound_reg && len_reg != '0)
                    begin
                        state_next = S_FIXED;
                        left_next = len_reg;
                    end
                    else
                    begin
                        state_next = S_DONE;
                        st = ST_COMPLETE;
                    end
                S_CLEN_START:
                    if (b == "0") state_next = S_TERM_CR;
                    else if (q_item.hex_ok)
                    begin
                        state_next = S_CLEN;
                        left_next = COUNT_BITS'(q_item.hex_val);
                    end
                    else st = ST_INVALID;
                S_CLEN:
                    if (b == 8'h0D) state_next = S_CLEN_NL;
                    else if (q_item.hex_ok)
                        left_next = (hex_acc[COUNT_BITS+3:COUNT_BITS] != 4'd0)
                                    ? CMAX : hex_acc[COUNT_BITS-1:0];
                    else st = ST_INVALID;
                S_CLEN_NL: if (b == 8'h0A) state_next = S_CHUNK; else st = ST_INVALID;
                S_CHUNK:
                    if (left_reg == '0)
                    begin
                        if (b == 8'h0D) state_next = S_CHUNK_NL;
                        else st = ST_INVALID;
                    end
                    else
                    begin
                        left_next = left_reg - 1'b1;
                        cls = CLS_BODY;
                    end
                S_CHUNK_NL: if (b == 8'h0A) state_next = S_CLEN_START; else st = ST_INVALID;
                S_TERM_CR: if (b == 8'h0D) state_next = S_TERM_LF; else st = ST_INVALID;
                S_TERM_LF: if (b == 8'h0A) state_next = S_TRAIL_START; else st = ST_INVALID;
                S_TRAIL_START: if (b == 8'h0D) state_next = S_TERM_NL; else st = ST_INVALID;
                S_TERM_NL:
                    if (b == 8'h0A)
                    begin
                        state_next = S_DONE;
                        st = ST_COMPLETE;
                    end
                    else st = ST_INVALID;
                S_FIXED:
                begin
                    cls = CLS_BODY;
                    if (left_reg <= COUNT_BITS'(1))
                    begin
                        left_next = '0;
                        state_next = S_DONE;
                        st = ST_COMPLETE;
                    end
                    else left_next = left_reg - 1'b1;
                end
                S_DONE: st = ST_INVALID;
                default: st = ST_INVALID;
            endcase
        end
        oitem_next.status = st;
        oitem_next.byte_class = cls;
        oitem_next.out_byte = (cls != CLS_NONE) ? b : 8'd0;
        oitem_next.header_done = hd;
        oitem_next.major_version = major_next;
        oitem_next.minor_version = minor_next;
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_METHOD_START;
            major_reg  <= '0;
            minor_reg  <= '0;
            left_reg   <= '0;
            len_reg    <= '0;
            seen_reg   <= 1'b0;
            lfound_reg <= 1'b0;
            pos_reg    <= '0;
            code_reg   <= V_NONE;
            flags_reg  <= 2'b11;
            enc_reg    <= ENC_NONE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                state_reg  <= state_next;
                major_reg  <= major_next;
                minor_reg  <= minor_next;
                left_reg   <= left_next;
                len_reg    <= len_next;
                seen_reg   <= seen_next;
                lfound_reg <= lfound_next;
                pos_reg    <= pos_next;
                code_reg   <= code_next;
                flags_reg  <= flags_next;
                enc_reg    <= enc_next;
            end
            if (q_ready)
            begin
                ovalid_reg <= q_valid;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            oitem_reg <= oitem_next;
        end
    end
endmodule
`default_nettype wire

// ----- sv/http_request_byte_parser.sv -----
// Top level of the HTTP request byte parser.
// Takes an HTTP/1.x request one byte per transfer and returns one result per byte:
// a status, the byte's class, the byte itself, a header-done flag and the parsed
// version. One byte is accepted every clock cycle while the output is not stalled;
// each byte passes a classifying register, a two-entry queue and the parse state
// machine, whose result is registered before it is offered on the output.
// Content-Length and chunk sizes saturate at COUNT_BITS bits.
`default_nettype none
`include "http_request_byte_parser_defines.svh"
module http_request_byte_parser #(
    parameter int COUNT_BITS = hrp_pkg::COUNT_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    hrp_stream_if.sink   in_ch,
    hrp_stream_if.source out_ch
);
    import hrp_pkg::*;

    logic      f_valid, f_ready, b_valid, b_ready;
    cls_item_t f_item, b_item;
    in_item_t  in_item;
    out_item_t out_item;

    assign in_item = in_ch.payload;
    assign out_ch.payload = out_item;

    // Front part: classify each transfer.
    hrp_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_item),
        .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
    );

    // Queue between the two parts.
    hrp_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
    );

    // Back part: parse state machine.
    hrp_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_item)
    );

    `HRP_ASSERT(a_status_range, clk, rst_n, out_ch.valid |-> out_item.status != 2'd3, "bad status")
    `HRP_ASSERT(a_class_byte, clk, rst_n, (out_ch.valid && out_item.byte_class == CLS_NONE) |-> out_item.out_byte == 8'd0, "byte without class")
    `HRP_ASSERT(a_hold, clk, rst_n, (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_item)), "result dropped")
    `HRP_ASSERT_NORST(a_rst_idle, clk, !rst_n |=> !out_ch.valid, "output valid after reset")
endmodule
`default_nettype wire

// ----- dv/http_request_byte_parser_tb.sv -----
// Self-checking testbench for the HTTP request byte parser, with a built-in parser model.
`default_nettype none
module http_request_byte_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hrp_pkg::*;

    localparam longint unsigned COUNT_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    logic clk;
    logic rst_n;

    hrp_stream_if #(.T(in_item_t))  in_ch ();
    hrp_stream_if #(.T(out_item_t)) out_ch ();

    http_request_byte_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Clock and the single reset at the start of the run.
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Request bytes waiting to be sent, and results the model expects.
    in_item_t  byte_q[$];
    out_item_t result_q[$];
    int        accepted_n;
    int        loaded_n;
    int        mismatch_n;
    bit        took;
    bit        pausing;
    bit        pause_done;
    bit        hold_done;
    int        hold_left;

    // Parser model state.
    state_t          ps;
    logic [7:0]      maj_v;
    logic [7:0]      min_v;
    longint unsigned left_n;
    longint unsigned clen_v;
    logic            any_hdr;
    logic [4:0]      npos;
    logic [1:0]      nflags;
    logic [4:0]      vcode;
    logic [1:0]      enc;
    logic            clen_seen;

    string te_name  = "transfer-encoding";
    string cl_name  = "content-length";
    string ck_word  = "chunked";
    string id_word  = "identity";

    function automatic logic ctl_char(input logic [7:0] b);
        return (b <= 8'd31) || (b == 8'd127);
    endfunction

    function automatic logic digit_char(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic tok_char(input logic [7:0] b);
        case (b)
            "(", ")", "<", "@", ",", ";", ":", "\\", "\"", "/", "[", "]",
            "?", "=", "{", "}", " ", 8'h09: return 1'b0;
            default: return (b <= 8'd127) && !ctl_char(b);
        endcase
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    // Hex digit value, or 16 when the byte is not a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        if (digit_char(b)) return 5'(b - "0");
        if (b >= "a" && b <= "f") return 5'(b - "a" + 8'd10);
        if (b >= "A" && b <= "F") return 5'(b - "A" + 8'd10);
        return 5'd16;
    endfunction

    function automatic longint unsigned acc_sat(input longint unsigned v,
        input longint unsigned d, input longint unsigned base, input longint unsigned lim);
        if (v > (lim - d) / base) return lim;
        return v * base + d;
    endfunction

    function automatic logic [4:0] enc_advance(input logic [4:0] c, input logic [7:0] l);
        if (c == V_TE0) return (l == "c") ? 5'd2 : ((l == "i") ? 5'd9 : V_TE_MISS);
        if (c >= 2 && c <= 7) return (l == ck_word[c - 1]) ? c + 5'd1 : V_TE_MISS;
        if (c >= 9 && c <= 15) return (l == id_word[c - 8]) ? c + 5'd1 : V_TE_MISS;
        return V_TE_MISS;
    endfunction

    task automatic clear_parser();
        ps = S_METHOD_START;
        maj_v = '0;
        min_v = '0;
        left_n = 0;
        clen_v = 0;
        any_hdr = 1'b0;
        npos = '0;
        nflags = 2'b11;
        vcode = V_NONE;
        enc = ENC_NONE;
        clen_seen = 1'b0;
    endtask

    // Track which of the two special header names is still possible.
    task automatic match_name(input logic [7:0] b);
        logic [7:0] l;
        l = fold_case(b);
        if (npos >= 17 || l != te_name[npos]) nflags &= 2'b10;
        if (npos >= 14 || l != cl_name[npos]) nflags &= 2'b01;
        if (npos < 31) npos = npos + 5'd1;
    endtask

    // One parser step: consume a byte or restart, and build the expected result.
    task automatic parse_byte(input in_item_t it, output out_item_t r);
        logic [1:0] st;
        logic [2:0] cls;
        logic       hd;
        logic [7:0] b;
        logic       tk;
        logic [4:0] code;
        st = ST_INCOMPLETE;
        cls = CLS_NONE;
        hd = 1'b0;
        b = it.data_byte;
        tk = tok_char(b);
        code = vcode;
        if (it.op == OP_RESTART)
        begin
            clear_parser();
        end
        else
        begin
            case (ps)
                S_METHOD_START:
                    if (tk) begin ps = S_METHOD; cls = CLS_METHOD; end
                    else st = ST_INVALID;
                S_METHOD:
                    if (b == " ") ps = S_URI;
                    else if (tk) cls = CLS_METHOD;
                    else st = ST_INVALID;
                S_URI:
                    if (b == " ") ps = S_VH;
                    else if (ctl_char(b)) st = ST_INVALID;
                    else cls = CLS_URI;
                S_VH: if (b == "H") ps = S_VT1; else st = ST_INVALID;
                S_VT1: if (b == "T") ps = S_VT2; else st = ST_INVALID;
                S_VT2: if (b == "T") ps = S_VP; else st = ST_INVALID;
                S_VP: if (b == "P") ps = S_VSLASH; else st = ST_INVALID;
                S_VSLASH:
                    if (b == "/") begin ps = S_MAJ_START; maj_v = '0; min_v = '0; end
                    else st = ST_INVALID;
                S_MAJ_START:
                    if (digit_char(b)) begin ps = S_MAJ; maj_v = b - "0"; end
                    else st = ST_INVALID;
                S_MAJ:
                    if (b == ".") ps = S_MIN_START;
                    else if (digit_char(b)) maj_v = 8'(acc_sat(maj_v, b - "0", 10, 255));
                    else st = ST_INVALID;
                S_MIN_START:
                    if (digit_char(b)) begin ps = S_MIN; min_v = b - "0"; end
                    else st = ST_INVALID;
                S_MIN:
                    if (b == 8'h0D) ps = S_NL1;
                    else if (digit_char(b)) min_v = 8'(acc_sat(min_v, b - "0", 10, 255));
                    else st = ST_INVALID;
                S_NL1: if (b == 8'h0A) ps = S_LINE_START; else st = ST_INVALID;
                S_LINE_START:
                    if (b == 8'h0D) ps = S_NL3;
                    else if (any_hdr && (b == " " || b == 8'h09)) ps = S_LWS;
                    else if (tk)
                    begin
                        ps = S_NAME;
                        cls = CLS_NAME;
                        npos = '0;
                        nflags = 2'b11;
                        vcode = V_NONE;
                        match_name(b);
                    end
                    else st = ST_INVALID;
                S_LWS:
                    if (b == 8'h0D) ps = S_NL2;
                    else if (b == " " || b == 8'h09) ;
                    else if (ctl_char(b) || code == V_CL_EMPTY || code == V_CL_DIGITS)
                        st = ST_INVALID;
                    else
                    begin
                        // A folded Transfer-Encoding value is never acceptable.
                        if (code >= V_TE0 && code <= V_TE_MISS)
                        begin
                            vcode = V_TE_MISS;
                            enc = ENC_OTHER;
                        end
                        ps = S_VALUE_CONT;
                        cls = CLS_VALUE;
                    end
                S_NAME:
                    if (b == ":")
                    begin
                        ps = S_SPACE;
                        vcode = V_NONE;
                        if (nflags[0] && npos == 17 && enc == ENC_NONE)
                        begin
                            enc = ENC_OTHER;
                            vcode = V_TE0;
                        end
                        else if (nflags[1] && npos == 14 && !clen_seen)
                        begin
                            clen_seen = 1'b1;
                            clen_v = 0;
                            vcode = V_CL_EMPTY;
                        end
                    end
                    else if (tk) begin cls = CLS_NAME; match_name(b); end
                    else st = ST_INVALID;
                S_SPACE: if (b == " ") ps = S_VALUE; else st = ST_INVALID;
                S_VALUE:
                    if (b == 8'h0D)
                    begin
                        if (code == V_CL_EMPTY) st = ST_INVALID;
                        else
                        begin
                            if (code >= V_TE0 && code <= V_TE_MISS)
                                enc = (code == V_CHUNKED_FULL) ? ENC_CHUNKED :
                                      ((code == V_IDENTITY_FULL) ? ENC_IDENTITY : ENC_OTHER);
                            ps = S_NL2;
                            hd = 1'b1;
                            any_hdr = 1'b1;
                        end
                    end
                    else if (ctl_char(b)) st = ST_INVALID;
                    else if (code == V_CL_EMPTY || code == V_CL_DIGITS)
                    begin
                        if (!digit_char(b)) st = ST_INVALID;
                        else
                        begin
                            clen_v = acc_sat(clen_v, b - "0", 10, COUNT_MAX);
                            vcode = V_CL_DIGITS;
                            cls = CLS_VALUE;
                        end
                    end
                    else
                    begin
                        if (code >= V_TE0 && code <= V_TE_MISS)
                            vcode = enc_advance(code, fold_case(b));
                        cls = CLS_VALUE;
                    end
                S_VALUE_CONT:
                    if (b == 8'h0D) ps = S_NL2;
                    else if (ctl_char(b)) st = ST_INVALID;
                    else cls = CLS_VALUE;
                S_NL2: if (b == 8'h0A) ps = S_LINE_START; else st = ST_INVALID;
                S_NL3:
                    if (b != 8'h0A || enc == ENC_OTHER) st = ST_INVALID;
                    else if (enc == ENC_CHUNKED) ps = S_CLEN_START;
                    else if (clen_seen && clen_v != 0) begin ps = S_FIXED; left_n = clen_v; end
                    else begin ps = S_DONE; st = ST_COMPLETE; end
                S_CLEN_START:
                    if (b == "0") ps = S_TERM_CR;
                    else if (hex_digit(b) < 16)
                    begin
                        ps = S_CLEN;
                        left_n = 64'(hex_digit(b));
                    end
                    else st = ST_INVALID;
                S_CLEN:
                    if (b == 8'h0D) ps = S_CLEN_NL;
                    else if (hex_digit(b) < 16) left_n = acc_sat(left_n, hex_digit(b), 16, COUNT_MAX);
                    else st = ST_INVALID;
                S_CLEN_NL: if (b == 8'h0A) ps = S_CHUNK; else st = ST_INVALID;
                S_CHUNK:
                    if (left_n == 0)
                    begin
                        if (b == 8'h0D) ps = S_CHUNK_NL; else st = ST_INVALID;
                    end
                    else begin left_n--; cls = CLS_BODY; end
                S_CHUNK_NL: if (b == 8'h0A) ps = S_CLEN_START; else st = ST_INVALID;
                S_TERM_CR: if (b == 8'h0D) ps = S_TERM_LF; else st = ST_INVALID;
                S_TERM_LF: if (b == 8'h0A) ps = S_TRAIL_START; else st = ST_INVALID;
                S_TRAIL_START: if (b == 8'h0D) ps = S_TERM_NL; else st = ST_INVALID;
                S_TERM_NL:
                    if (b == 8'h0A) begin ps = S_DONE; st = ST_COMPLETE; end
                    else st = ST_INVALID;
                S_FIXED:
                begin
                    cls = CLS_BODY;
                    if (left_n > 0) left_n--;
                    if (left_n == 0) begin ps = S_DONE; st = ST_COMPLETE; end
                end
                default: st = ST_INVALID;
            endcase
        end
        r.status = st;
        r.byte_class = cls;
        r.out_byte = (cls != CLS_NONE) ? b : 8'd0;
        r.header_done = hd;
        r.major_version = maj_v;
        r.minor_version = min_v;
    endtask

    // Stimulus helpers.
    task automatic send_byte(input logic [7:0] b);
        in_item_t it;
        it.op = OP_BYTE;
        it.data_byte = b;
        byte_q.insert(byte_q.size(), it);
    endtask

    task automatic send_restart();
        in_item_t it;
        it.op = OP_RESTART;
        it.data_byte = 8'($urandom_range(255));
        byte_q.insert(byte_q.size(), it);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Send text with random case changes and, rarely, a stray byte.
    task automatic send_mixed(input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'd32;
            if ($urandom_range(99) < 3) send_byte(8'($urandom_range(255)));
            send_byte(c);
        end
    endtask

    function automatic logic [7:0] pick_tok();
        logic [7:0] c;
        do c = 8'($urandom_range(127)); while (!tok_char(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_text();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (ctl_char(c) || c == " ");
        return c;
    endfunction

    task automatic send_digits(input int n);
        for (int i = 0; i < n; i++)
            send_byte(8'("0" + $urandom_range(9)));
    endtask

    // One request with random content; the body kind is chosen per request.
    task automatic send_request();
        int kind;
        int n;
        int sz;
        string hx;
        kind = $urandom_range(4);
        send_restart();
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_byte(pick_tok());
        send_byte(" ");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) send_byte(pick_text());
        send_byte(" ");
        send_text("HTTP/");
        send_digits($urandom_range(1, ($urandom_range(9) == 0) ? 5 : 1));
        send_byte(".");
        send_digits($urandom_range(1, ($urandom_range(9) == 0) ? 5 : 1));
        send_text("\r\n");
        n = $urandom_range(0, 2);
        for (int h = 0; h < n; h++)
        begin
            sz = $urandom_range(1, 8);
            for (int i = 0; i < sz; i++) send_byte(pick_tok());
            send_text(": ");
            sz = $urandom_range(0, 5);
            for (int i = 0; i < sz; i++) send_byte(pick_text());
            send_text("\r\n");
            // Folded continuation line.
            if ($urandom_range(3) == 0)
            begin
                send_byte($urandom_range(1) ? " " : 8'h09);
                send_byte(pick_text());
                send_text("\r\n");
            end
        end
        case (kind)
            1, 4:
            begin
                send_mixed("content-length: ");
                if ($urandom_range(15) == 0) send_digits(22);
                else send_byte(8'("0" + $urandom_range(0, 6)));
                send_text("\r\n");
                if (kind == 4) begin send_mixed("transfer-encoding: identity"); send_text("\r\n"); end
                if (kind == 4 && $urandom_range(3) == 0)
                begin
                    send_text(" x\r\n");
                end
                send_text("\r\n");
                n = $urandom_range(0, 7);
                for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
            end
            2:
            begin
                send_mixed("transfer-encoding: chunked");
                send_text("\r\n");
                if ($urandom_range(7) == 0) begin send_text("\tz\r\n"); end
                send_text("\r\n");
                n = $urandom_range(0, 2);
                for (int c = 0; c < n; c++)
                begin
                    sz = $urandom_range(1, 6);
                    hx = $sformatf("%h", sz[3:0]);
                    send_mixed(hx);
                    if ($urandom_range(15) == 0) send_text("FFFFFFFFFFFFFFFFFF");
                    send_text("\r\n");
                    for (int i = 0; i < sz; i++) send_byte(8'($urandom_range(255)));
                    send_text("\r\n");
                end
                send_text("0\r\n\r\n");
            end
            3:
            begin
                send_mixed("transfer-encoding: gzip\r\n\r\n");
            end
            default:
                send_text("\r\n");
        endcase
        // Bytes after completion are refused.
        if ($urandom_range(3) == 0) send_byte(8'($urandom_range(255)));
    endtask

    // Stimulus, end of run.
    initial
    begin
        accepted_n = 0;
        loaded_n = 0;
        mismatch_n = 0;
        took = 1'b0;
        pausing = 1'b0;
        pause_done = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        clear_parser();

        // Directed: both byte extremes refused, saturating version, no body.
        send_restart();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("G / HTTP/999.300\r\n\r\n");

        while (byte_q.size() < 950)
        begin
            if ($urandom_range(19) == 0)
            begin
                for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(255)));
            end
            send_request();
        end

        wait (rst_n);
        while (byte_q.size() != 0 || in_ch.valid || result_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_n == 0 && result_q.size() == 0)
            $display("http_request_byte_parser_tb: PASS");
        else
            $display("http_request_byte_parser_tb: FAIL");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("http_request_byte_parser_tb: FAIL");
        $finish;
    end

    // Idle behavior changes every hundred accepted transfers.
    function automatic int idle_phase();
        return (accepted_n / 100) % 4;
    endfunction

    // Sender: hold valid until the transfer completes, then maybe load the next byte.
    always @(negedge clk)
    begin
        logic     keep;
        logic     idle;
        in_item_t nxt;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.payload <= '0;
        end
        else
        begin
            keep = in_ch.valid && !took;
            took = 1'b0;
            if (pausing && !keep && result_q.size() == 0) pausing = 1'b0;
            case (idle_phase())
                1: idle = ($urandom_range(99) < 58);
                3: idle = ($urandom_range(99) < 28);
                default: idle = 1'b0;
            endcase
            if (keep)
                ;
            else if (byte_q.size() != 0 && !idle && !pausing)
            begin
                nxt = byte_q.pop_front();
                loaded_n++;
                if (loaded_n == 600 && !pause_done)
                begin
                    pausing = 1'b1;
                    pause_done = 1'b1;
                end
                in_ch.payload <= nxt;
                in_ch.valid <= 1'b1;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Receiver: random stalls, and one long hold that backs up the input.
    always @(negedge clk)
    begin
        logic rdy;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (accepted_n >= 300 && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            case (idle_phase())
                2: rdy = ($urandom_range(99) >= 58);
                3: rdy = ($urandom_range(99) >= 28);
                default: rdy = 1'b1;
            endcase
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            out_ch.ready <= rdy;
        end
    end

    // Input transfers feed the model; output transfers are checked against it.
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            parse_byte(in_ch.payload, want);
            result_q.insert(result_q.size(), want);
            accepted_n++;
            took = 1'b1;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.payload;
            if (result_q.size() == 0)
            begin
                mismatch_n++;
                if (mismatch_n <= 10)
                    $display("%t: result with nothing expected: %h", $realtime, got);
            end
            else
            begin
                want = result_q.pop_front();
                if (got.status !== want.status || got.byte_class !== want.byte_class ||
                    got.out_byte !== want.out_byte || got.header_done !== want.header_done ||
                    got.major_version !== want.major_version ||
                    got.minor_version !== want.minor_version)
                begin
                    mismatch_n++;
                    if (mismatch_n <= 10)
                        $display({"%t: mismatch status %0d/%0d class %0d/%0d byte %h/%h ",
                                  "hdr %0d/%0d major %0d/%0d minor %0d/%0d (expected/actual)"},
                                 $realtime, want.status, got.status, want.byte_class,
                                 got.byte_class, want.out_byte, got.out_byte,
                                 want.header_done, got.header_done, want.major_version,
                                 got.major_version, want.minor_version, got.minor_version);
                end
            end
        end
    end

endmodule
`default_nettype wire
